@@ design/p3nt_pkg.sv @@
package p3nt_pkg;

	localparam int MAX_BLOCKS      = 4096;
	localparam int MAX_PROCS       = 64;
	localparam int NEIGHBOUR_SLOTS = 27;
	localparam int ID_W            = 12;
	localparam int BLK_W           = 13;
	localparam int CELL_W          = 16;
	localparam int ORG_W           = 28;
	localparam int PROC_W          = 6;
	localparam int PCNT_W          = 7;
	localparam int SLOT_W          = 5;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;

	localparam logic [1:0] OP_WR_PERM  = 2'd0;
	localparam logic [1:0] OP_WR_LOCAL = 2'd1;
	localparam logic [1:0] OP_WR_START = 2'd2;
	localparam logic [1:0] OP_QUERY    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PROCS    = 3'd6;

	// divider pass select
	localparam logic [1:0] DIV_X = 2'd0;
	localparam logic [1:0] DIV_Y = 2'd1;
	localparam logic [1:0] DIV_Z = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       div_start;
		logic       div_store;
		logic [1:0] div_sel;
		logic       origin;
		logic       coord;
		logic       mul1;
		logic       mul2;
		logic       rd_perm;
		logic       rd_local;
		logic       srch_rd;
		logic       srch_cmp;
		logic       advance;
	} p3nt_cmd_t;

	typedef struct packed {
		logic is_query;
		logic div_busy;
		logic srch_more;
		logic last_slot;
	} p3nt_sts_t;

endpackage

@@ design/p3nt_dp.sv @@
module p3nt_dp import p3nt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  p3nt_cmd_t             cmd,
	output p3nt_sts_t             sts,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]            operation,
	input  logic [ID_W-1:0]       table_index,
	input  logic [BLK_W-1:0]      table_value,
	input  logic [ID_W-1:0]       block_id,
	output logic [ID_W-1:0]       query_block,
	output logic [1:0]            edge_flag_x,
	output logic [1:0]            edge_flag_y,
	output logic [1:0]            edge_flag_z,
	output logic [ORG_W-1:0]      origin_x,
	output logic [ORG_W-1:0]      origin_y,
	output logic [ORG_W-1:0]      origin_z,
	output logic [SLOT_W-1:0]     neighbour_slot,
	output logic [ID_W-1:0]       neighbour_block,
	output logic [PROC_W-1:0]     neighbour_process,
	output logic [ID_W-1:0]       neighbour_local,
	output logic                  last_result
);

	function automatic logic [BLK_W-1:0] wrap_step(input logic [BLK_W-1:0] c,
			input logic [BLK_W-1:0] n, input logic [1:0] d);
		logic [BLK_W-1:0] r;
		r = c;
		if (d == 2'd0) begin
			r = (c == '0) ? n - 1'b1 : c - 1'b1;
		end else if (d == 2'd2) begin
			r = (c == n - 1'b1) ? '0 : c + 1'b1;
		end
		return r;
	endfunction

	logic [BLK_W-1:0]  blocks_x_q, blocks_y_q, blocks_z_q;
	logic [CELL_W-1:0] cells_x_q, cells_y_q, cells_z_q;
	logic [PCNT_W-1:0] procs_q;
	logic [BLK_W-1:0]  nx, ny, nz;
	logic [PCNT_W-1:0] pc_eff;

	logic [ID_W-1:0]  id_q;
	logic [ID_W-1:0]  dvd_q;
	logic [BLK_W-1:0] rem_q, dvs_q;
	logic [3:0]       div_cnt_q;
	logic             div_busy_q;
	logic [BLK_W:0]   trial;
	logic             qbit;

	logic [BLK_W-1:0] cx_q, cy_q, czr_q;
	logic [ID_W-1:0]  qx_q, cz_q;
	logic [1:0]       fx_q, fy_q, fz_q;
	logic [ORG_W-1:0] ox_q, oy_q, oz_q;

	logic [1:0]        dx_q, dy_q, dz_q;
	logic [SLOT_W-1:0] slot_q;
	logic [BLK_W-1:0]  px_q, py_q, pz_q;
	logic [ID_W-1:0]   t_q, lin_q, nb_q, loc_q;
	logic [2*BLK_W-1:0] prod_t;
	logic [BLK_W+ID_W-1:0] prod_l;

	logic [PROC_W-1:0] base_q;
	logic [PCNT_W-1:0] cnt_q;
	logic [PROC_W-1:0] half;
	logic [BLK_W-1:0]  ps_q;

	logic [ID_W-1:0]  perm_mem  [MAX_BLOCKS];
	logic [ID_W-1:0]  local_mem [MAX_BLOCKS];
	logic [BLK_W-1:0] start_mem [MAX_PROCS];

	assign nx = (blocks_x_q == '0) ? BLK_W'(1) : blocks_x_q;
	assign ny = (blocks_y_q == '0) ? BLK_W'(1) : blocks_y_q;
	assign nz = (blocks_z_q == '0) ? BLK_W'(1) : blocks_z_q;
	assign pc_eff = (procs_q == '0) ? PCNT_W'(1) :
		(procs_q > PCNT_W'(MAX_PROCS)) ? PCNT_W'(MAX_PROCS) : procs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_x_q <= BLK_W'(1);
			blocks_y_q <= BLK_W'(1);
			blocks_z_q <= BLK_W'(1);
			cells_x_q  <= CELL_W'(1);
			cells_y_q  <= CELL_W'(1);
			cells_z_q  <= CELL_W'(1);
			procs_q    <= PCNT_W'(1);
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_BLOCKS_X: blocks_x_q <= cfg_data[BLK_W-1:0];
				CFG_BLOCKS_Y: blocks_y_q <= cfg_data[BLK_W-1:0];
				CFG_BLOCKS_Z: blocks_z_q <= cfg_data[BLK_W-1:0];
				CFG_CELLS_X:  cells_x_q  <= cfg_data;
				CFG_CELLS_Y:  cells_y_q  <= cfg_data;
				CFG_CELLS_Z:  cells_z_q  <= cfg_data;
				CFG_PROCS:    procs_q    <= cfg_data[PCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// table stores
	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OP_WR_PERM) begin
			perm_mem[table_index] <= table_value[ID_W-1:0];
		end
		if (cmd.rd_perm) begin
			nb_q <= perm_mem[lin_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OP_WR_LOCAL) begin
			local_mem[table_index] <= table_value[ID_W-1:0];
		end
		if (cmd.rd_local) begin
			loc_q <= local_mem[nb_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OP_WR_START && table_index[ID_W-1:PROC_W] == '0) begin
			start_mem[table_index[PROC_W-1:0]] <= table_value;
		end
		if (cmd.srch_rd) begin
			ps_q <= start_mem[base_q + half];
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[ID_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 4'(ID_W - 1);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			if (div_cnt_q == '0) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			case (cmd.div_sel)
				DIV_X: begin
					dvd_q <= id_q;
					dvs_q <= nx;
				end
				DIV_Y: begin
					dvd_q <= qx_q;
					dvs_q <= ny;
				end
				default: begin
					dvd_q <= cz_q;
					dvs_q <= nz;
				end
			endcase
		end else if (div_busy_q) begin
			rem_q <= qbit ? BLK_W'(trial - {1'b0, dvs_q}) : trial[BLK_W-1:0];
			dvd_q <= {dvd_q[ID_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q <= block_id;
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				DIV_X: begin
					cx_q <= rem_q;
					qx_q <= dvd_q;
				end
				DIV_Y: begin
					cy_q <= rem_q;
					cz_q <= dvd_q;
				end
				default: czr_q <= rem_q;
			endcase
		end
		if (cmd.origin) begin
			fx_q <= {cx_q == nx - 1'b1, cx_q == '0};
			fy_q <= {cy_q == ny - 1'b1, cy_q == '0};
			fz_q <= {{1'b0, cz_q} == nz - 1'b1, cz_q == '0};
			ox_q <= ORG_W'(cells_x_q * cx_q);
			oy_q <= ORG_W'(cells_y_q * cy_q);
			oz_q <= ORG_W'(cells_z_q * cz_q);
		end
		if (cmd.coord) begin
			px_q <= wrap_step(cx_q, nx, dx_q);
			py_q <= wrap_step(cy_q, ny, dy_q);
			pz_q <= wrap_step(czr_q, nz, dz_q);
		end
		if (cmd.mul1) begin
			t_q <= prod_t[ID_W-1:0];
		end
		if (cmd.mul2) begin
			lin_q <= prod_l[ID_W-1:0];
		end
	end

	// linear id only matters modulo the table depth
	assign prod_t = ny * pz_q + (2*BLK_W)'(py_q);
	assign prod_l = nx * t_q + (BLK_W+ID_W)'(px_q);

	// slot counters, x fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q   <= '0;
			dy_q   <= '0;
			dz_q   <= '0;
			slot_q <= '0;
		end else if (cmd.accept) begin
			dx_q   <= '0;
			dy_q   <= '0;
			dz_q   <= '0;
			slot_q <= '0;
		end else if (cmd.advance) begin
			slot_q <= slot_q + 1'b1;
			if (dx_q == 2'd2) begin
				dx_q <= '0;
				if (dy_q == 2'd2) begin
					dy_q <= '0;
					dz_q <= dz_q + 1'b1;
				end else begin
					dy_q <= dy_q + 1'b1;
				end
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	// owner search: halve the range, take the upper half when not below its start
	assign half = cnt_q[PCNT_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.rd_local) begin
			base_q <= '0;
			cnt_q  <= pc_eff;
		end else if (cmd.srch_cmp) begin
			if ({1'b0, nb_q} < ps_q) begin
				cnt_q <= PCNT_W'(half);
			end else begin
				base_q <= base_q + half;
				cnt_q  <= cnt_q - PCNT_W'(half);
			end
		end
	end

	assign sts.is_query  = (operation == OP_QUERY);
	assign sts.div_busy  = div_busy_q;
	assign sts.srch_more = (cnt_q > PCNT_W'(1));
	assign sts.last_slot = (slot_q == SLOT_W'(NEIGHBOUR_SLOTS - 1));

	assign query_block       = id_q;
	assign edge_flag_x       = fx_q;
	assign edge_flag_y       = fy_q;
	assign edge_flag_z       = fz_q;
	assign origin_x          = ox_q;
	assign origin_y          = oy_q;
	assign origin_z          = oz_q;
	assign neighbour_slot    = slot_q;
	assign neighbour_block   = nb_q;
	assign neighbour_process = base_q;
	assign neighbour_local   = loc_q;
	assign last_result       = sts.last_slot;

endmodule

@@ design/p3nt_ctrl.sv @@
module p3nt_ctrl import p3nt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  p3nt_sts_t sts,
	output p3nt_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_ORIGIN, ST_COORD, ST_MUL1, ST_MUL2,
		ST_RD_PERM, ST_RD_LOCAL, ST_SRCH_A, ST_SRCH_B, ST_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] sel_q;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.div_sel   = sel_q;
		cmd.accept    = in_valid && (state_q == ST_IDLE);
		cmd.div_start = (state_q == ST_DIV_GO);
		cmd.div_store = (state_q == ST_DIV_WAIT) && !sts.div_busy;
		cmd.origin    = (state_q == ST_ORIGIN);
		cmd.coord     = (state_q == ST_COORD);
		cmd.mul1      = (state_q == ST_MUL1);
		cmd.mul2      = (state_q == ST_MUL2);
		cmd.rd_perm   = (state_q == ST_RD_PERM);
		cmd.rd_local  = (state_q == ST_RD_LOCAL);
		cmd.srch_rd   = (state_q == ST_SRCH_A) && sts.srch_more;
		cmd.srch_cmp  = (state_q == ST_SRCH_B);
		cmd.advance   = (state_q == ST_EMIT) && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= DIV_X;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && sts.is_query) begin
						sel_q   <= DIV_X;
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (!sts.div_busy) begin
						if (sel_q == DIV_Z) begin
							state_q <= ST_ORIGIN;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_ORIGIN:   state_q <= ST_COORD;
				ST_COORD:    state_q <= ST_MUL1;
				ST_MUL1:     state_q <= ST_MUL2;
				ST_MUL2:     state_q <= ST_RD_PERM;
				ST_RD_PERM:  state_q <= ST_RD_LOCAL;
				ST_RD_LOCAL: state_q <= ST_SRCH_A;
				ST_SRCH_A: begin
					if (sts.srch_more) begin
						state_q <= ST_SRCH_B;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_SRCH_B: state_q <= ST_SRCH_A;
				ST_EMIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= sts.last_slot ? ST_IDLE : ST_COORD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/periodic_3d_neighbour_table_unit.sv @@
// Neighbour table for a periodic 3D grid of blocks.
// Input channel (in_valid / in_stall): each item is either a table write
// (permutation, local index or partition start) or a query for one block id.
// A write gives no result. A query gives 27 result items,
// one per neighbour slot with x fastest; last_result marks slot 26.
// Output channel (out_valid / out_stall): a result is held on the ports until
// taken; while out_stall is high the block holds the item and waits.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; write registers only while no query is in flight.
// Sequence: a query splits the id in three passes through a 12-bit restoring
// divider and then sets flags and origins. Each slot then takes a coordinate
// step, two multiplies and two table reads, then a binary search over the
// partition starts (ceil(log2(process_count)) steps, one start-table read
// each), the final search check and the output handshake.
// in_stall stays high from a query's acceptance until its last result is taken.
// Reset clears control state and sets all registers to 1; table contents are
// undefined until written.
module periodic_3d_neighbour_table_unit import p3nt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            operation,
	input  logic [ID_W-1:0]       table_index,
	input  logic [BLK_W-1:0]      table_value,
	input  logic [ID_W-1:0]       block_id,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ID_W-1:0]       query_block,
	output logic [1:0]            edge_flag_x,
	output logic [1:0]            edge_flag_y,
	output logic [1:0]            edge_flag_z,
	output logic [ORG_W-1:0]      origin_x,
	output logic [ORG_W-1:0]      origin_y,
	output logic [ORG_W-1:0]      origin_z,
	output logic [SLOT_W-1:0]     neighbour_slot,
	output logic [ID_W-1:0]       neighbour_block,
	output logic [PROC_W-1:0]     neighbour_process,
	output logic [ID_W-1:0]       neighbour_local,
	output logic                  last_result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	p3nt_cmd_t cmd;
	p3nt_sts_t sts;

	// registers take every write at once
	assign cfg_ready = 1'b1;

	p3nt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	p3nt_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_wr            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.operation         (operation),
		.table_index       (table_index),
		.table_value       (table_value),
		.block_id          (block_id),
		.query_block       (query_block),
		.edge_flag_x       (edge_flag_x),
		.edge_flag_y       (edge_flag_y),
		.edge_flag_z       (edge_flag_z),
		.origin_x          (origin_x),
		.origin_y          (origin_y),
		.origin_z          (origin_z),
		.neighbour_slot    (neighbour_slot),
		.neighbour_block   (neighbour_block),
		.neighbour_process (neighbour_process),
		.neighbour_local   (neighbour_local),
		.last_result       (last_result)
	);

endmodule

@@ bench/periodic_3d_neighbour_table_unit_tb.sv @@
`timescale 1ns / 1ps

module periodic_3d_neighbour_table_unit_tb;
	import p3nt_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int HOLD_CYCLES    = 700;
	// low table entries loaded up front; random grids stay within this many blocks
	localparam int FILL_DEPTH     = 64;

	// One neighbour entry as the block should present it.
	typedef struct {
		logic [ID_W-1:0]   qblk;
		logic [1:0]        fx, fy, fz;
		logic [ORG_W-1:0]  ox, oy, oz;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   nblk;
		logic [PROC_W-1:0] nproc;
		logic [ID_W-1:0]   nlocal;
		logic              last;
	} nbr_entry_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            operation;
	logic [ID_W-1:0]       table_index;
	logic [BLK_W-1:0]      table_value;
	logic [ID_W-1:0]       block_id;
	logic                  out_valid;
	logic                  out_stall;
	logic [ID_W-1:0]       query_block;
	logic [1:0]            edge_flag_x;
	logic [1:0]            edge_flag_y;
	logic [1:0]            edge_flag_z;
	logic [ORG_W-1:0]      origin_x;
	logic [ORG_W-1:0]      origin_y;
	logic [ORG_W-1:0]      origin_z;
	logic [SLOT_W-1:0]     neighbour_slot;
	logic [ID_W-1:0]       neighbour_block;
	logic [PROC_W-1:0]     neighbour_process;
	logic [ID_W-1:0]       neighbour_local;
	logic                  last_result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the block's registers and tables.
	logic [BLK_W-1:0]  sh_blocks [3];
	logic [CELL_W-1:0] sh_cells [3];
	logic [PCNT_W-1:0] sh_procs;
	logic [ID_W-1:0]   perm_tbl [MAX_BLOCKS];
	logic [ID_W-1:0]   local_tbl [MAX_BLOCKS];
	logic [BLK_W-1:0]  start_tbl [MAX_PROCS];

	nbr_entry_t nbr_pending[$];
	int         mismatches;
	int         idle_count;
	bit         gaps_on;
	bit         hold_req;

	periodic_3d_neighbour_table_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.table_index       (table_index),
		.table_value       (table_value),
		.block_id          (block_id),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.query_block       (query_block),
		.edge_flag_x       (edge_flag_x),
		.edge_flag_y       (edge_flag_y),
		.edge_flag_z       (edge_flag_z),
		.origin_x          (origin_x),
		.origin_y          (origin_y),
		.origin_z          (origin_z),
		.neighbour_slot    (neighbour_slot),
		.neighbour_block   (neighbour_block),
		.neighbour_process (neighbour_process),
		.neighbour_local   (neighbour_local),
		.last_result       (last_result),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Binary search over the partition starts: take the upper half when the
	// id is not below its first start.
	function automatic logic [PROC_W-1:0] find_owner(longint unsigned id);
		longint unsigned cnt;
		longint unsigned base;
		longint unsigned half;
		cnt = sh_procs;
		base = 0;
		if (cnt == 0) cnt = 1;
		if (cnt > MAX_PROCS) cnt = MAX_PROCS;
		while (cnt > 1) begin
			half = cnt / 2;
			if (id < start_tbl[base + half]) begin
				cnt = half;
			end else begin
				base += half;
				cnt -= half;
			end
		end
		return base[PROC_W-1:0];
	endfunction

	function automatic logic [1:0] edge_bits(longint unsigned c, longint unsigned n);
		return {c == n - 1, c == 0};
	endfunction

	// Apply one accepted item to the shadow tables, or queue the 27
	// neighbour entries a query should produce.
	function automatic void predict_neighbours(logic [1:0] op, logic [ID_W-1:0] idx,
			logic [BLK_W-1:0] val, logic [ID_W-1:0] id);
		longint unsigned nx, ny, nz, cx, cy, cz, px, py, pz, lin;
		nbr_entry_t e;
		int k;
		case (op)
			OP_WR_PERM: begin
				perm_tbl[idx] = val[ID_W-1:0];
			end
			OP_WR_LOCAL: begin
				local_tbl[idx] = val[ID_W-1:0];
			end
			OP_WR_START: begin
				// drop writes past the last partition slot
				if (idx < MAX_PROCS) start_tbl[idx] = val;
			end
			default: begin
				nx = (sh_blocks[0] == 0) ? 1 : sh_blocks[0];
				ny = (sh_blocks[1] == 0) ? 1 : sh_blocks[1];
				nz = (sh_blocks[2] == 0) ? 1 : sh_blocks[2];
				cx = id % nx;
				cy = (id / nx) % ny;
				// z stays an unreduced quotient for flags and origin
				cz = id / (nx * ny);
				e.qblk = id;
				e.fx = edge_bits(cx, nx);
				e.fy = edge_bits(cy, ny);
				e.fz = edge_bits(cz, nz);
				e.ox = ORG_W'(sh_cells[0] * cx);
				e.oy = ORG_W'(sh_cells[1] * cy);
				e.oz = ORG_W'(sh_cells[2] * cz);
				k = 0;
				for (int dz = 0; dz < 3; dz++) begin
					for (int dy = 0; dy < 3; dy++) begin
						for (int dx = 0; dx < 3; dx++) begin
							px = (cx + dx + nx - 1) % nx;
							py = (cy + dy + ny - 1) % ny;
							pz = (cz + dz + nz - 1) % nz;
							lin = (px + nx * (py + ny * pz)) % MAX_BLOCKS;
							e.slot = k[SLOT_W-1:0];
							e.nblk = perm_tbl[lin];
							e.nproc = find_owner(e.nblk);
							e.nlocal = local_tbl[e.nblk];
							e.last = (k == NEIGHBOUR_SLOTS - 1);
							nbr_pending.push_back(e);
							k++;
						end
					end
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string field, longint unsigned got,
			longint unsigned want);
		mismatches++;
		$display("mismatch %0t: %s got %0d want %0d", $realtime, field, got, want);
	endtask

	// Compare every accepted result with the oldest pending entry.
	always @(posedge clk) begin
		nbr_entry_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (nbr_pending.size() == 0) begin
				report_mismatch("unexpected result, slot", neighbour_slot, 0);
			end else begin
				e = nbr_pending.pop_front();
				if (query_block !== e.qblk) report_mismatch("query_block", query_block, e.qblk);
				if (edge_flag_x !== e.fx) report_mismatch("edge_flag_x", edge_flag_x, e.fx);
				if (edge_flag_y !== e.fy) report_mismatch("edge_flag_y", edge_flag_y, e.fy);
				if (edge_flag_z !== e.fz) report_mismatch("edge_flag_z", edge_flag_z, e.fz);
				if (origin_x !== e.ox) report_mismatch("origin_x", origin_x, e.ox);
				if (origin_y !== e.oy) report_mismatch("origin_y", origin_y, e.oy);
				if (origin_z !== e.oz) report_mismatch("origin_z", origin_z, e.oz);
				if (neighbour_slot !== e.slot)
					report_mismatch("neighbour_slot", neighbour_slot, e.slot);
				if (neighbour_block !== e.nblk)
					report_mismatch("neighbour_block", neighbour_block, e.nblk);
				if (neighbour_process !== e.nproc)
					report_mismatch("neighbour_process", neighbour_process, e.nproc);
				if (neighbour_local !== e.nlocal)
					report_mismatch("neighbour_local", neighbour_local, e.nlocal);
				if (last_result !== e.last) report_mismatch("last_result", last_result, e.last);
			end
		end
	end

	// Watchdog: end the run after too many cycles with no handshake at all.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver side: random stall bursts, plus one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Offer one item at the falling edge, maybe after a gap, and hold it
	// until accepted.
	task automatic send_item(logic [1:0] op, logic [ID_W-1:0] idx,
			logic [BLK_W-1:0] val, logic [ID_W-1:0] id);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		table_index = idx;
		table_value = val;
		block_id = id;
		do @(posedge clk); while (in_stall);
		predict_neighbours(op, idx, val, id);
	endtask

	// Wait for all pending results, then let any write still in the pipe
	// settle before the registers change.
	task automatic drain_block();
		@(negedge clk);
		in_valid = 1'b0;
		while (nbr_pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BLOCKS_X: sh_blocks[0] = data[BLK_W-1:0];
			CFG_BLOCKS_Y: sh_blocks[1] = data[BLK_W-1:0];
			CFG_BLOCKS_Z: sh_blocks[2] = data[BLK_W-1:0];
			CFG_CELLS_X:  sh_cells[0] = data;
			CFG_CELLS_Y:  sh_cells[1] = data;
			CFG_CELLS_Z:  sh_cells[2] = data;
			CFG_PROCS:    sh_procs = data[PCNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_grid(int bx, int by, int bz, int kx, int ky, int kz, int procs);
		drain_block();
		write_reg(CFG_BLOCKS_X, CFG_DATA_W'(bx));
		write_reg(CFG_BLOCKS_Y, CFG_DATA_W'(by));
		write_reg(CFG_BLOCKS_Z, CFG_DATA_W'(bz));
		write_reg(CFG_CELLS_X, CFG_DATA_W'(kx));
		write_reg(CFG_CELLS_Y, CFG_DATA_W'(ky));
		write_reg(CFG_CELLS_Z, CFG_DATA_W'(kz));
		write_reg(CFG_PROCS, CFG_DATA_W'(procs));
	endtask

	// Permutation value that points into the loaded part of the local table.
	function automatic logic [BLK_W-1:0] perm_value();
		return BLK_W'($urandom_range(0, FILL_DEPTH - 1));
	endfunction

	// Ascending start value for slot idx that keeps the partition sorted.
	function automatic logic [BLK_W-1:0] sorted_start(int idx);
		int lo;
		int hi;
		lo = (idx == 0) ? 0 : start_tbl[idx - 1];
		hi = (idx == MAX_PROCS - 1) ? MAX_BLOCKS : start_tbl[idx + 1];
		if (hi < lo) hi = lo;
		return BLK_W'($urandom_range(lo, hi));
	endfunction

	// Load the low table entries; random grids stay within them and the directed
	// test loads the far ones it reads, so no query ever reads an unwritten one.
	task automatic test_table_fill();
		int acc;
		for (int i = 0; i < FILL_DEPTH; i++)
			send_item(OP_WR_PERM, ID_W'(i), perm_value(), '0);
		for (int i = 0; i < FILL_DEPTH; i++)
			send_item(OP_WR_LOCAL, ID_W'(i), BLK_W'($urandom_range(0, MAX_BLOCKS)), '0);
		acc = 0;
		for (int i = 0; i < MAX_PROCS; i++) begin
			send_item(OP_WR_START, ID_W'(i), BLK_W'(acc), '0);
			acc += $urandom_range(0, 120);
		end
	endtask

	// Extremes of each field and corner cases.
	task automatic test_directed();
		set_grid(4, 3, 2, 16'hffff, 1, 300, MAX_PROCS);
		send_item(OP_QUERY, '0, '0, '0);
		send_item(OP_QUERY, '0, '0, 12'd23);
		send_item(OP_QUERY, '0, '0, 12'd5);
		// id past the grid: z quotient beyond blocks_z
		send_item(OP_QUERY, '0, '0, 12'hfff);
		// start write past the partition table is dropped
		send_item(OP_WR_START, 12'hfff, 13'h1fff, '0);
		send_item(OP_WR_PERM, 12'hfff, 13'h1000, '0);
		send_item(OP_WR_LOCAL, 12'hfff, 13'h0fff, '0);
		send_item(OP_QUERY, '0, '0, 12'h800);
		// zero block counts act as one, zero processes act as one
		set_grid(0, 0, 0, 0, 16'hffff, 16'h8000, 0);
		send_item(OP_QUERY, '0, '0, '0);
		send_item(OP_QUERY, '0, '0, 12'h7ff);
		// largest grid and a capped process count; load the far entries read
		set_grid(MAX_BLOCKS, MAX_BLOCKS, MAX_BLOCKS, 1, 2, 3, 100);
		send_item(OP_WR_PERM, 12'hffe, perm_value(), '0);
		send_item(OP_QUERY, '0, '0, '0);
		send_item(OP_QUERY, '0, '0, 12'hfff);
		set_grid(1, MAX_BLOCKS, 1, 16'h1234, 16'hfedc, 16'hffff, 2);
		for (int d = -1; d <= 1; d++) begin
			send_item(OP_WR_PERM, ID_W'(12'h555 + d), perm_value(), '0);
			send_item(OP_WR_PERM, ID_W'(12'haaa + d), perm_value(), '0);
		end
		send_item(OP_QUERY, '0, '0, 12'h555);
		send_item(OP_QUERY, '0, '0, 12'haaa);
	endtask

	// Mostly queries with random content, some table updates and noise.
	task automatic test_random_phase(int count);
		int r;
		int idx;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				send_item(OP_QUERY, ID_W'($urandom), BLK_W'($urandom), ID_W'($urandom));
			end else if (r == 7) begin
				send_item(OP_WR_PERM, ID_W'($urandom), perm_value(), ID_W'($urandom));
			end else if (r == 8) begin
				send_item(OP_WR_LOCAL, ID_W'($urandom),
					BLK_W'($urandom_range(0, MAX_BLOCKS)), ID_W'($urandom));
			end else begin
				idx = $urandom_range(0, 127);
				if (idx < MAX_PROCS)
					send_item(OP_WR_START, ID_W'(idx), sorted_start(idx), ID_W'($urandom));
				else
					send_item(OP_WR_START, ID_W'(idx), BLK_W'($urandom), ID_W'($urandom));
			end
		end
	endtask

	task automatic test_random();
		int bx;
		int by;
		int bz;
		for (int p = 0; p < 4; p++) begin
			bx = $urandom_range(1, 16);
			by = $urandom_range(1, FILL_DEPTH / bx);
			bz = $urandom_range(1, FILL_DEPTH / (bx * by));
			set_grid(bx, by, bz, $urandom, $urandom, $urandom, $urandom_range(1, MAX_PROCS));
			test_random_phase(30);
		end
	endtask

	// Hold off the receiver for a long stretch while queries keep coming.
	task automatic test_backpressure();
		set_grid(5, 4, 3, 7, 11, 13, MAX_PROCS);
		hold_req = 1'b1;
		for (int n = 0; n < 4; n++)
			send_item(OP_QUERY, '0, '0, ID_W'($urandom));
	endtask

	// Back-to-back items with no idling on either side.
	task automatic test_full_rate();
		set_grid(3, 3, 3, $urandom, $urandom, $urandom, 33);
		gaps_on = 1'b0;
		test_random_phase(40);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_QUERY;
		table_index = '0;
		table_value = '0;
		block_id = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BLOCKS_X;
		cfg_data = '0;
		mismatches = 0;
		idle_count = 0;
		hold_req = 1'b0;
		gaps_on = 1'b1;
		sh_blocks = '{1, 1, 1};
		sh_cells = '{1, 1, 1};
		sh_procs = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_fill();
		test_directed();
		test_random();
		test_backpressure();
		test_full_rate();
		drain_block();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
design/p3nt_pkg.sv
design/p3nt_dp.sv
design/p3nt_ctrl.sv
design/periodic_3d_neighbour_table_unit.sv
bench/periodic_3d_neighbour_table_unit_tb.sv
